// ===== sv/isc_pkg.sv =====
// Shared types and codes for the interleave string checker.
package isc_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR         = 3'd0,
    CMD_APPEND_FIRST  = 3'd1,
    CMD_APPEND_SECOND = 3'd2,
    CMD_APPEND_TARGET = 3'd3,
    CMD_EVALUATE      = 3'd4
  } isc_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } isc_state_e;

  typedef struct packed {
    logic       valid;
    logic       row0;
    logic       reach;
    logic [7:0] fc;
  } isc_link_t;

endpackage

// ===== sv/interleave_string_check_core.sv =====
// Top level: sequencer plus a chain of table column cells.
//
// channel  direction  ports                              handshake
// command  in         cmd_i, char_in_i                   start_i && !busy_o
// result   out        is_interleave_o, overflow_o        valid_o, one cycle
//
// Clear and append leave busy_o low.
// Evaluate with matching lengths and no overflow holds busy_o through ST_RUN and
// ST_DONE; the verdict set in ST_DONE is registered onto valid_o.
// The sweep steps the skewed cell chain once per cycle, one target byte a step.
// Otherwise evaluate answers with valid_o in the next cycle.
// Reset is asynchronous and empties all strings; the receiver cannot stall.
module interleave_string_check_core
  import isc_pkg::*;
#(
  parameter int MaxLen = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_in_i,
  output logic       valid_o,
  output logic       is_interleave_o,
  output logic       overflow_o
);

  localparam int FLW = $clog2(MaxLen + 1);

  isc_link_t      link_w [MaxLen + 1];
  logic [7:0]     tc;
  logic           sec_we;
  logic [FLW-1:0] sec_len;

  isc_ctrl #(.MaxLen(MaxLen)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .char_in_i       (char_in_i),
    .valid_o         (valid_o),
    .is_interleave_o (is_interleave_o),
    .overflow_o      (overflow_o),
    .link_o          (link_w[0]),
    .tc_o            (tc),
    .sec_we_o        (sec_we),
    .sec_len_o       (sec_len),
    .final_reach_i   (link_w[sec_len].reach)
  );

  for (genvar g = 0; g < MaxLen; g++) begin : g_cell
    isc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .link_i (link_w[g]),
      .tc_i   (tc),
      .we_i   (sec_we && (sec_len == FLW'(g))),
      .char_i (char_in_i),
      .link_o (link_w[g + 1])
    );
  end

endmodule

// ===== sv/isc_cell.sv =====
// One table column cell: holds a second-source byte and its reach bit.
module isc_cell
  import isc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  isc_link_t  link_i,
  input  logic [7:0] tc_i,
  input  logic       we_i,
  input  logic [7:0] char_i,
  output isc_link_t  link_o
);

  logic       valid_q, row0_q, reach_q;
  logic       reach_d;
  logic [7:0] fc_q, s_q;

  always_comb begin
    reach_d = (!link_i.row0 && reach_q && (link_i.fc == tc_i)) ||
              (link_i.reach && (s_q == tc_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row0_q  <= 1'b0;
    end else begin
      valid_q <= link_i.valid;
      row0_q  <= link_i.row0;
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q <= link_i.fc;
    if (link_i.valid) begin
      reach_q <= reach_d;
    end
    if (we_i) begin
      s_q <= char_i;
    end
  end

  assign link_o = '{valid: valid_q, row0: row0_q, reach: reach_q, fc: fc_q};

endmodule

// ===== sv/isc_ctrl.sv =====
// Command sequencer: string stores, lengths, overflow flag and table sweep.
module isc_ctrl
  import isc_pkg::*;
#(
  parameter int MaxLen = 64,
  localparam int FLW = $clog2(MaxLen + 1),
  localparam int TLW = $clog2(2 * MaxLen + 1),
  localparam int FAW = (MaxLen > 1) ? $clog2(MaxLen) : 1,
  localparam int TAW = $clog2(2 * MaxLen)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [2:0]     cmd_i,
  input  logic [7:0]     char_in_i,
  output logic           valid_o,
  output logic           is_interleave_o,
  output logic           overflow_o,
  output isc_link_t      link_o,
  output logic [7:0]     tc_o,
  output logic           sec_we_o,
  output logic [FLW-1:0] sec_len_o,
  input  logic           final_reach_i
);

  isc_state_e state_q, state_d;

  logic [FLW-1:0] first_len_q, first_len_d;
  logic [FLW-1:0] second_len_q, second_len_d;
  logic [TLW-1:0] target_len_q, target_len_d;
  logic           ovf_q, ovf_d;
  logic [TLW-1:0] k_q, k_d;
  logic           col0_q, col0_d;
  logic           out_valid_q, out_valid_d;
  logic           out_hit_q, out_hit_d;
  logic           out_ovf_q, out_ovf_d;
  isc_link_t      link_q, link_d;

  logic           accept;
  logic           first_we, target_we;
  logic           row_ok;

  logic [7:0] first_mem [MaxLen];
  logic [7:0] target_mem [2 * MaxLen];
  logic [7:0] first_rd_q, target_rd_q;

  assign accept = start_i && (state_q == ST_IDLE);
  assign row_ok = (k_q <= TLW'(first_len_q));

  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    target_len_d = target_len_q;
    ovf_d        = ovf_q;
    k_d          = k_q;
    col0_d       = col0_q;
    out_valid_d  = 1'b0;
    out_hit_d    = out_hit_q;
    out_ovf_d    = out_ovf_q;
    link_d       = '{valid: 1'b0, row0: 1'b0, reach: col0_q, fc: first_rd_q};
    first_we     = 1'b0;
    target_we    = 1'b0;
    sec_we_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_CLEAR: begin
              first_len_d  = '0;
              second_len_d = '0;
              target_len_d = '0;
              ovf_d        = 1'b0;
            end
            CMD_APPEND_FIRST: begin
              if (first_len_q < FLW'(MaxLen)) begin
                first_we    = 1'b1;
                first_len_d = first_len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_APPEND_SECOND: begin
              if (second_len_q < FLW'(MaxLen)) begin
                sec_we_o     = 1'b1;
                second_len_d = second_len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_APPEND_TARGET: begin
              if (target_len_q < TLW'(2 * MaxLen)) begin
                target_we    = 1'b1;
                target_len_d = target_len_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_EVALUATE: begin
              out_ovf_d = ovf_q;
              if (ovf_q ||
                  (TLW'(first_len_q) + TLW'(second_len_q) != target_len_q)) begin
                out_valid_d = 1'b1;
                out_hit_d   = 1'b0;
              end else begin
                k_d     = '0;
                state_d = ST_RUN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RUN: begin
        if (row_ok) begin
          col0_d = (k_q == '0) ? 1'b1 : (col0_q && (first_rd_q == target_rd_q));
        end
        link_d.valid = row_ok;
        link_d.row0  = (k_q == '0);
        link_d.reach = col0_d;
        k_d          = k_q + 1'b1;
        if (k_q == target_len_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_d = 1'b1;
        out_hit_d   = final_reach_i;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_len_q  <= '0;
      second_len_q <= '0;
      target_len_q <= '0;
      ovf_q        <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
      link_q       <= '0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      target_len_q <= target_len_d;
      ovf_q        <= ovf_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
      link_q       <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col0_q    <= col0_d;
    out_hit_q <= out_hit_d;
    out_ovf_q <= out_ovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[first_len_q[FAW-1:0]] <= char_in_i;
    end
    if (target_we) begin
      target_mem[target_len_q[TAW-1:0]] <= char_in_i;
    end
    first_rd_q  <= first_mem[k_q[FAW-1:0]];
    target_rd_q <= target_mem[k_q[TAW-1:0]];
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = out_valid_q;
  assign is_interleave_o = out_hit_q;
  assign overflow_o      = out_ovf_q;
  assign link_o          = link_q;
  assign tc_o            = target_rd_q;
  assign sec_len_o       = second_len_q;

`ifndef SYNTHESIS
  a_no_result_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i != CMD_EVALUATE)) |=> !valid_o)
    else $error("result after a non-evaluate transfer");
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q <= target_len_q))
    else $error("sweep step past target length");
  a_hit_without_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && is_interleave_o) |-> !overflow_o)
    else $error("match reported with overflow");
  a_ovf_from_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> $past(accept && ((cmd_i == CMD_APPEND_FIRST) ||
      (cmd_i == CMD_APPEND_SECOND) || (cmd_i == CMD_APPEND_TARGET))))
    else $error("overflow raised without an append");
`endif

endmodule

// ===== dv/interleave_string_check_core_checker.sv =====
// Checker for the interleave string checker: predicts each evaluate verdict and compares results.
module interleave_string_check_core_checker
  import isc_pkg::*;
#(
  parameter int MaxLen = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_in_i,
  input  logic       valid_i,
  input  logic       is_interleave_i,
  input  logic       overflow_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic is_interleave;
    logic overflow;
  } verdict_t;

  logic [7:0] first_str  [MaxLen];
  logic [7:0] second_str [MaxLen];
  logic [7:0] target_str [2*MaxLen];
  int         first_len;
  int         second_len;
  int         target_len;
  logic       overflow_seen;
  verdict_t   verdict_q [$];
  int         failures = 0;

  function automatic logic interleave_holds();
    logic       reach [MaxLen+1];
    logic [7:0] fc;
    logic [7:0] tc;
    if (overflow_seen) return 1'b0;
    if (first_len + second_len != target_len) return 1'b0;
    reach[0] = 1'b1;
    for (int j = 1; j <= second_len; j++) begin
      reach[j] = reach[j-1] && (second_str[j-1] == target_str[j-1]);
    end
    for (int i = 1; i <= first_len; i++) begin
      fc = first_str[i-1];
      reach[0] = reach[0] && (fc == target_str[i-1]);
      for (int j = 1; j <= second_len; j++) begin
        tc = target_str[i+j-1];
        reach[j] = (reach[j] && (fc == tc)) || (reach[j-1] && (second_str[j-1] == tc));
      end
    end
    return reach[second_len];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] verdict check: %s", $time, msg);
    failures++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    verdict_t want;
    if (!rst_ni) begin
      first_len     = 0;
      second_len    = 0;
      target_len    = 0;
      overflow_seen = 1'b0;
      verdict_q.delete();
      pending_o    <= 0;
      fail_count_o <= failures;
    end else begin
      if (valid_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result transfer with no evaluate outstanding");
        end else begin
          want = verdict_q.pop_front();
          if (is_interleave_i !== want.is_interleave) begin
            report_mismatch($sformatf("is_interleave got %b want %b",
                                      is_interleave_i, want.is_interleave));
          end
          if (overflow_i !== want.overflow) begin
            report_mismatch($sformatf("overflow got %b want %b",
                                      overflow_i, want.overflow));
          end
        end
      end
      if (start_i && !busy_i) begin
        case (cmd_i)
          CMD_CLEAR: begin
            first_len     = 0;
            second_len    = 0;
            target_len    = 0;
            overflow_seen = 1'b0;
          end
          CMD_APPEND_FIRST: begin
            if (first_len < MaxLen) begin
              first_str[first_len] = char_in_i;
              first_len++;
            end else begin
              overflow_seen = 1'b1;
            end
          end
          CMD_APPEND_SECOND: begin
            if (second_len < MaxLen) begin
              second_str[second_len] = char_in_i;
              second_len++;
            end else begin
              overflow_seen = 1'b1;
            end
          end
          CMD_APPEND_TARGET: begin
            if (target_len < 2*MaxLen) begin
              target_str[target_len] = char_in_i;
              target_len++;
            end else begin
              overflow_seen = 1'b1;
            end
          end
          CMD_EVALUATE: begin
            want.is_interleave = interleave_holds();
            want.overflow      = overflow_seen;
            verdict_q.push_back(want);
          end
          default: ;
        endcase
      end
      pending_o    <= verdict_q.size();
      fail_count_o <= failures;
    end
  end

endmodule

// ===== dv/interleave_string_check_core_tb.sv =====
// Testbench top for the interleave string checker: clock, reset, command stimulus and verdict.
module interleave_string_check_core_tb;
  import isc_pkg::*;

  localparam int         MaxLen       = 64;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef enum int {
    SEQ_MATCH,
    SEQ_MUTATE,
    SEQ_SWAP,
    SEQ_LENGTH,
    SEQ_OVERFLOW
  } seq_kind_e;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       start_i   = 1'b0;
  logic [2:0] cmd_i     = CMD_CLEAR;
  logic [7:0] char_in_i = 8'h00;
  logic       busy_o;
  logic       valid_o;
  logic       is_interleave_o;
  logic       overflow_o;
  int         fail_count;
  int         pending;
  int         idle_pct = 0;
  int         issued   = 0;

  interleave_string_check_core #(
    .MaxLen(MaxLen)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .char_in_i      (char_in_i),
    .valid_o        (valid_o),
    .is_interleave_o(is_interleave_o),
    .overflow_o     (overflow_o)
  );

  interleave_string_check_core_checker #(
    .MaxLen(MaxLen)
  ) verdict_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .char_in_i      (char_in_i),
    .valid_i        (valid_o),
    .is_interleave_i(is_interleave_o),
    .overflow_i     (overflow_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #12_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic issue(input logic [2:0] c, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    cmd_i     <= c;
    char_in_i <= b;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (c <= CMD_EVALUATE) issued++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_sym(input logic [7:0] base, input int spread);
    if (spread >= 255) return 8'($urandom);
    return base ^ 8'($urandom_range(spread));
  endfunction

  task automatic run_sequence(input int la, input int lb, input seq_kind_e kind);
    logic [7:0] a_q [$];
    logic [7:0] b_q [$];
    logic [7:0] t_q [$];
    logic [7:0] base;
    logic [7:0] tmp;
    int         spread;
    int         ia;
    int         ib;
    int         it;
    int         pos;
    int         pick;
    int         lane;
    int         extra;
    base = 8'($urandom);
    case ($urandom_range(2))
      0:       spread = 1;
      1:       spread = 3;
      default: spread = 255;
    endcase
    for (int i = 0; i < la; i++) a_q.push_back(pick_sym(base, spread));
    for (int i = 0; i < lb; i++) b_q.push_back(pick_sym(base, spread));
    ia = 0;
    ib = 0;
    while (ia < la || ib < lb) begin
      if (ib >= lb || (ia < la && $urandom_range(1) == 0)) begin
        t_q.push_back(a_q[ia]);
        ia++;
      end else begin
        t_q.push_back(b_q[ib]);
        ib++;
      end
    end
    case (kind)
      SEQ_MUTATE: begin
        if (t_q.size() > 0) begin
          pos = $urandom_range(t_q.size() - 1);
          t_q[pos] = t_q[pos] ^ 8'($urandom_range(1, 255));
        end
      end
      SEQ_SWAP: begin
        if (t_q.size() > 1) begin
          pos = $urandom_range(t_q.size() - 2);
          tmp = t_q[pos];
          t_q[pos] = t_q[pos+1];
          t_q[pos+1] = tmp;
        end
      end
      SEQ_LENGTH: begin
        if (t_q.size() > 0 && $urandom_range(1) == 0) tmp = t_q.pop_back();
        else t_q.push_back(pick_sym(base, spread));
      end
      SEQ_OVERFLOW: begin
        extra = $urandom_range(1, 3);
        case ($urandom_range(2))
          0:       while (a_q.size() < MaxLen + extra) a_q.push_back(pick_sym(base, spread));
          1:       while (b_q.size() < MaxLen + extra) b_q.push_back(pick_sym(base, spread));
          default: while (t_q.size() < 2*MaxLen + extra) t_q.push_back(pick_sym(base, spread));
        endcase
      end
      default: ;
    endcase
    if (kind == SEQ_OVERFLOW || $urandom_range(9) != 0) issue(CMD_CLEAR, 8'($urandom));
    ia = 0;
    ib = 0;
    it = 0;
    while (ia < a_q.size() || ib < b_q.size() || it < t_q.size()) begin
      pick = $urandom_range(99);
      lane = $urandom_range(2);
      if (pick < 2) begin
        issue(CMD_EVALUATE, 8'($urandom));
      end else if (pick < 5) begin
        issue(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), 8'($urandom));
      end else if (lane == 0 && ia < a_q.size()) begin
        issue(CMD_APPEND_FIRST, a_q[ia]);
        ia++;
      end else if (lane == 1 && ib < b_q.size()) begin
        issue(CMD_APPEND_SECOND, b_q[ib]);
        ib++;
      end else if (it < t_q.size()) begin
        issue(CMD_APPEND_TARGET, t_q[it]);
        it++;
      end else if (ia < a_q.size()) begin
        issue(CMD_APPEND_FIRST, a_q[ia]);
        ia++;
      end else begin
        issue(CMD_APPEND_SECOND, b_q[ib]);
        ib++;
      end
    end
    issue(CMD_EVALUATE, 8'($urandom));
    if ($urandom_range(4) == 0) issue(CMD_EVALUATE, 8'($urandom));
  endtask

  task automatic random_sequence();
    int        pick;
    int        la;
    int        lb;
    seq_kind_e kind;
    if ($urandom_range(19) == 0) begin
      la = $urandom_range(MaxLen);
      lb = $urandom_range(MaxLen);
    end else begin
      la = $urandom_range(8);
      lb = $urandom_range(8);
    end
    pick = $urandom_range(99);
    if (pick < 45)      kind = SEQ_MATCH;
    else if (pick < 65) kind = SEQ_MUTATE;
    else if (pick < 80) kind = SEQ_SWAP;
    else if (pick < 95) kind = SEQ_LENGTH;
    else                kind = SEQ_OVERFLOW;
    run_sequence(la, lb, kind);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(CMD_EVALUATE, 8'hFF);
    issue(CMD_SPARE_LO, 8'h00);
    issue(CMD_SPARE_LO + 3'd1, 8'hFF);
    issue(CMD_SPARE_HI, 8'hFF);
    issue(CMD_EVALUATE, 8'h00);
    issue(CMD_APPEND_FIRST, 8'h00);
    issue(CMD_APPEND_SECOND, 8'hFF);
    issue(CMD_APPEND_TARGET, 8'hFF);
    issue(CMD_APPEND_TARGET, 8'h00);
    issue(CMD_EVALUATE, 8'h00);
    issue(CMD_APPEND_TARGET, 8'h5A);
    issue(CMD_EVALUATE, 8'hA5);
    issue(CMD_CLEAR, 8'hFF);
    issue(CMD_APPEND_FIRST, 8'hFF);
    issue(CMD_APPEND_TARGET, 8'hFF);
    issue(CMD_EVALUATE, 8'h00);
    issue(CMD_APPEND_SECOND, 8'h01);
    issue(CMD_APPEND_TARGET, 8'h10);
    issue(CMD_EVALUATE, 8'hFF);
    issue(CMD_CLEAR, 8'h00);
    issue(CMD_EVALUATE, 8'h00);
    drain();

    idle_pct = 37;
    run_sequence(MaxLen, MaxLen, SEQ_MATCH);
    run_sequence(2, 1, SEQ_OVERFLOW);
    while (issued < 270) random_sequence();
    drain();

    idle_pct = 61;
    while (issued < 520) random_sequence();
    drain();

    idle_pct = 0;
    while (issued < 770) random_sequence();
    drain();
    repeat (2*MaxLen + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== interleave_string_check_core.f =====
sv/isc_pkg.sv
sv/isc_cell.sv
sv/isc_ctrl.sv
sv/interleave_string_check_core.sv
dv/interleave_string_check_core_checker.sv
dv/interleave_string_check_core_tb.sv
